// ===== hdl/rlm_pkg.sv =====
// rlm_pkg: shared types, constants and command/status structs for the rms level meter
// used by every module of the block, no dependencies

package rlm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_FRAME    = 1024;

    localparam int SUM_W   = 41;
    localparam int CNT_W   = 11;
    localparam int VOL_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int PROD_W  = 2 * SAMPLE_WIDTH - 1;
    localparam int MEAN_W  = 32;
    localparam int ROOT_W  = MEAN_W / 2;
    localparam int DIVR_W  = 16;

    localparam int SQRT_REM_W = ROOT_W + 2;
    localparam int SQRT_SH_W  = SQRT_REM_W + 2;

    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int SQRT_CNT_W = $clog2(ROOT_W);

    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_FRAME - 1);
    localparam logic [VOL_W-1:0] VOL_ONE   = 16'h8000;
    localparam logic [2:0]       LEVEL_MAX = 3'd6;

    localparam logic [CFG_W-1:0] DECAY_RST     = 16'd27853;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd164;
    localparam logic [CFG_W-1:0] FULL_SCALE_RST = 16'd9830;

    localparam logic [IDX_W-1:0] REG_MUTED      = 2'd0;
    localparam logic [IDX_W-1:0] REG_DECAY      = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD  = 2'd2;
    localparam logic [IDX_W-1:0] REG_FULL_SCALE = 2'd3;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                     action;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           frame_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       meter_level;
        logic [VOL_W-1:0] volume;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_SQRT_WAIT,
        ST_VOL_WAIT,
        ST_TICK
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic square;
        logic accum;
        logic div_start;
        logic div_vol;
        logic sqrt_start;
        logic store_vol;
        logic tick;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic muted;
        logic close_frame;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/rlm_div.sv =====
// rlm_div: restoring divider, one quotient bit per cycle
// depends on rlm_pkg

module rlm_div
    import rlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              done,
    output logic [SUM_W-1:0]  quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [DIVR_W-1:0]    rem_reg, rem_next;
    logic [DIVR_W-1:0]    dvs_reg, dvs_next;

    logic [DIVR_W:0] rem_shift;
    logic [DIVR_W:0] rem_diff;
    logic            fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_CNT_W'(DIV_STEPS - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // for a nonzero divisor the remainder stays below it, so it fits the divisor width
            rem_next = fits ? rem_diff[DIVR_W-1:0] : rem_shift[DIVR_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/rlm_sqrt.sv =====
// rlm_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on rlm_pkg

module rlm_sqrt
    import rlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MEAN_W-1:0] radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SQRT_CNT_W-1:0] step_reg, step_next;
    logic [MEAN_W-1:0]     x_reg, x_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [SQRT_REM_W-1:0] rem_reg, rem_next;

    logic [SQRT_SH_W-1:0] rem_shift;
    logic [SQRT_SH_W-1:0] trial;
    logic [SQRT_SH_W-1:0] rem_diff;
    logic                 ge;

    always_comb
    begin
        rem_shift = {rem_reg, x_reg[MEAN_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        rem_diff  = rem_shift - trial;
        ge        = (rem_shift >= trial);

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        root_next = root_reg;
        rem_next  = rem_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = SQRT_CNT_W'(ROOT_W - 1);
            x_next    = radicand;
            root_next = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // partial remainder is bounded by twice the partial root
            rem_next  = ge ? rem_diff[SQRT_REM_W-1:0] : rem_shift[SQRT_REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            x_next    = {x_reg[MEAN_W-3:0], 2'b00};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/rlm_datapath.sv =====
// rlm_datapath: config registers, square accumulator, volume register and output register
// depends on rlm_pkg, rlm_div, rlm_sqrt

module rlm_datapath
    import rlm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         in_data,
    input  logic             cfg_valid,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  ctrl_cmd_t        cmd,
    input  logic             out_ready,
    output dp_status_t       status,
    output logic             out_valid,
    output out_item_t        out_data
);

    logic             muted_reg;
    logic [CFG_W-1:0] decay_reg;
    logic [CFG_W-1:0] threshold_reg;
    logic [CFG_W-1:0] full_scale_reg;

    in_item_t          item_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VOL_W-1:0]  vol_reg, vol_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg;

    logic [SAMPLE_WIDTH-1:0]   raw;
    logic [SAMPLE_WIDTH-1:0]   mag;
    logic [2*SAMPLE_WIDTH-1:0] square;

    logic              div_done;
    logic [SUM_W-1:0]  div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic [SUM_W-1:0]  div_quotient;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic [VOL_W-1:0]  new_vol;

    logic [VOL_W-1:0] vol_eff;
    logic [VOL_W+2:0] times7;
    logic [2:0]       level;
    logic [31:0]      decay_prod;
    logic [VOL_W:0]   decayed;
    logic [VOL_W-1:0] decayed_sat;

    // magnitude of the sample; the most negative code maps to 1.0
    always_comb
    begin
        raw    = item_reg.sample;
        mag    = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;
        square = mag * mag;
    end

    assign div_dividend = cmd.div_vol ? SUM_W'({sqrt_root, 15'b0}) : sum_reg;
    assign div_divisor  = cmd.div_vol ? full_scale_reg : DIVR_W'(cnt_reg);

    rlm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    rlm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (div_quotient[MEAN_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        // zero full scale saturates, otherwise clamp the ratio to 1.0
        if (full_scale_reg == '0)
            new_vol = VOL_ONE;
        else if (div_quotient > SUM_W'(VOL_ONE))
            new_vol = VOL_ONE;
        else
            new_vol = div_quotient[VOL_W-1:0];
    end

    always_comb
    begin
        vol_eff    = (vol_reg < threshold_reg) ? '0 : vol_reg;
        times7     = {vol_eff, 3'b000} - {3'b000, vol_eff};
        level      = (times7[VOL_W+1:15] > LEVEL_MAX) ? LEVEL_MAX : times7[VOL_W+1:15];
        decay_prod = vol_reg * decay_reg;
        decayed    = decay_prod[31:15];
        decayed_sat = (decayed > {1'b0, VOL_ONE}) ? VOL_ONE : decayed[VOL_W-1:0];
    end

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        vol_next = vol_reg;
        if (cmd.accum)
        begin
            sum_next = sum_reg + SUM_W'(prod_reg);
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.store_vol)
        begin
            sum_next = '0;
            cnt_next = '0;
            vol_next = new_vol;
        end
        if (cmd.tick)
            vol_next = decayed_sat;
        if (cmd.clear)
            vol_next = '0;

        out_valid_next = out_valid_reg;
        if (cmd.tick)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            muted_reg      <= 1'b0;
            decay_reg      <= DECAY_RST;
            threshold_reg  <= THRESHOLD_RST;
            full_scale_reg <= FULL_SCALE_RST;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            vol_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MUTED:      muted_reg      <= cfg_data[0];
                    REG_DECAY:      decay_reg      <= cfg_data;
                    REG_THRESHOLD:  threshold_reg  <= cfg_data;
                    REG_FULL_SCALE: full_scale_reg <= cfg_data;
                    default:        ;
                endcase
            end
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            vol_reg       <= vol_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_data;
        if (cmd.square)
            prod_reg <= square[PROD_W-1:0];
        if (cmd.tick)
        begin
            out_reg.meter_level <= level;
            out_reg.volume      <= vol_eff;
        end
    end

    always_comb
    begin
        status.muted       = muted_reg;
        status.close_frame = item_reg.frame_end || (cnt_reg == CNT_LAST);
        status.div_done    = div_done;
        status.sqrt_done   = sqrt_done;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/rlm_ctrl.sv =====
// rlm_ctrl: controller state machine sequencing the datapath per item
// depends on rlm_pkg

module rlm_ctrl
    import rlm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_action,
    input  dp_status_t status,
    output logic       in_ready,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    unique case (in_action)
                        ACT_SAMPLE:
                        begin
                            // muted samples leave no trace
                            if (!status.muted)
                                state_next = ST_SQUARE;
                        end
                        ACT_TICK:  state_next = ST_TICK;
                        ACT_CLEAR: cmd.clear = 1'b1;
                        default:   ;
                    endcase
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = status.close_frame ? ST_MEAN_START : ST_IDLE;
            end
            ST_MEAN_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT:
            begin
                if (status.sqrt_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_vol   = 1'b1;
                    state_next    = ST_VOL_WAIT;
                end
            end
            ST_VOL_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.store_vol = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.tick   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/rms_level_meter_with_decay_core.sv =====
// rms level meter top: a sample is squared, then accumulated; a frame-closing sample
// also runs two 41-step divider runs and a 16-step root run in series
// a tick waits for any unaccepted item to leave the output register; a clear, a muted
// sample or an ignored item is handled in the idle state; one item in flight at a time
// async active-low reset clears the controller, sums, volume and sets config to defaults
// depends on rlm_pkg, rlm_ctrl, rlm_datapath

module rms_level_meter_with_decay_core
    import rlm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rlm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    rlm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== tb/sv/rms_level_meter_with_decay_core_test.sv =====
// testbench for rms_level_meter_with_decay_core: directed table then random bursts,
// each reading checked against its typed table row or a predictor of rms, volume and decay
// depends on rlm_pkg and rms_level_meter_with_decay_core

module rms_level_meter_with_decay_core_test;
    import rlm_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 150;
    localparam int BURSTS = 16;
    localparam int BURST_ITEMS = 50;
    localparam int LONG_FRAME_BURST = 12;
    localparam int LONG_FRAME_LEN = 1040;

    typedef struct packed {
        logic             is_reg;
        logic [IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0] reg_val;
        in_item_t         item;
        logic             typed;
        out_item_t        reading;
    } row_t;

    localparam int ROWS = 30;
    localparam row_t SCRIPT [ROWS] = '{
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b1, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_CLEAR, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_NONE, 16'h7fff, 1'b1}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_SAMPLE, 16'h8000, 1'b1}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b1, '{3'd6, 16'h8000}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'hffff, 1'b1}, 1'b1, '{3'd5, 16'd27853}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_SAMPLE, 16'h7fff, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_SAMPLE, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_SAMPLE, 16'h0001, 1'b1}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_CLEAR, 16'hffff, 1'b1}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b1, '{3'd0, 16'd0}},
        // partial frame survives both the mute window and the clear
        '{1'b0, REG_MUTED, 16'd0, '{ACT_SAMPLE, 16'h1234, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b1, REG_MUTED, 16'd1, '{ACT_TICK, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_SAMPLE, 16'h7fff, 1'b1}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b1, '{3'd0, 16'd0}},
        '{1'b1, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_CLEAR, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_SAMPLE, 16'hff00, 1'b1}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b1, REG_THRESHOLD, 16'h8000, '{ACT_TICK, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        // zero full scale saturates the volume
        '{1'b1, REG_FULL_SCALE, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b1, REG_DECAY, 16'h8000, '{ACT_TICK, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_SAMPLE, 16'h0000, 1'b1}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b1, '{3'd6, 16'h8000}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b1, '{3'd6, 16'h8000}},
        '{1'b1, REG_DECAY, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b0, '{3'd0, 16'd0}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b1, '{3'd6, 16'h8000}},
        '{1'b0, REG_MUTED, 16'd0, '{ACT_TICK, 16'h0000, 1'b0}, 1'b1, '{3'd0, 16'd0}}
    };

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // predictor state and register copy
    logic [63:0]      sq_sum = '0;
    int               frame_len = 0;
    logic [63:0]      held_vol = '0;
    logic             cfg_muted = 1'b0;
    logic [CFG_W-1:0] cfg_decay = DECAY_RST;
    logic [CFG_W-1:0] cfg_thresh = THRESHOLD_RST;
    logic [CFG_W-1:0] cfg_full_scale = FULL_SCALE_RST;

    out_item_t pending_readings[$];
    int        errors = 0;
    int        send_idle = 21;
    int        recv_stall = 65;
    int        frame_amp = 32768;

    rms_level_meter_with_decay_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 20; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic void predict_reading(input in_item_t it, output bit got,
                                            output out_item_t rd);
        int          s;
        int          mag;
        logic [63:0] mean;
        logic [63:0] vol;
        logic [63:0] shown;
        logic [63:0] lvl;
        got = 1'b0;
        rd = '0;
        if (it.action == ACT_SAMPLE && !cfg_muted)
        begin
            s = it.sample;
            mag = (s < 0) ? -s : s;
            sq_sum += 64'(mag) * 64'(mag);
            frame_len++;
            if (it.frame_end || frame_len >= MAX_FRAME)
            begin
                mean = (frame_len != 0) ? sq_sum / 64'(frame_len) : '0;
                if (cfg_full_scale == 0)
                    vol = 64'(VOL_ONE);
                else
                    vol = (isqrt(mean) << 15) / 64'(cfg_full_scale);
                if (vol > 64'(VOL_ONE))
                    vol = 64'(VOL_ONE);
                held_vol = vol;
                sq_sum = '0;
                frame_len = 0;
            end
        end
        else if (it.action == ACT_TICK)
        begin
            shown = held_vol;
            held_vol = (held_vol * 64'(cfg_decay)) >> 15;
            if (held_vol > 64'(VOL_ONE))
                held_vol = 64'(VOL_ONE);
            if (shown < 64'(cfg_thresh))
                shown = '0;
            lvl = (shown * 7) >> 15;
            if (lvl > 64'(LEVEL_MAX))
                lvl = 64'(LEVEL_MAX);
            rd.meter_level = lvl[2:0];
            rd.volume = shown[VOL_W-1:0];
            got = 1'b1;
        end
        else if (it.action == ACT_CLEAR)
            held_vol = '0;
    endfunction

    function automatic in_item_t random_item();
        int       r;
        in_item_t it;
        r = $urandom_range(0, 99);
        it.sample = 16'($urandom_range(0, 2 * frame_amp - 1) - frame_amp);
        it.frame_end = 1'($urandom_range(0, 1));
        if (r < 55)
        begin
            it.action = ACT_SAMPLE;
            it.frame_end = ($urandom_range(0, 5) == 0);
            // new loudness class for each frame
            if (it.frame_end)
                case ($urandom_range(0, 3))
                    0: frame_amp = 32768;
                    1: frame_amp = 4096;
                    2: frame_amp = 300;
                    default: frame_amp = 20;
                endcase
        end
        else if (r < 88)
            it.action = ACT_TICK;
        else if (r < 95)
            it.action = ACT_CLEAR;
        else
            it.action = ACT_NONE;
        return it;
    endfunction

    task automatic offer_item(input in_item_t it, input logic typed, input out_item_t typed_rd);
        bit        got;
        out_item_t rd;
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_reading(it, got, rd);
        if (got)
            pending_readings.push_back(typed ? typed_rd : rd);
    endtask

    // drain all readings, then give a frame close time to finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MUTED:      cfg_muted = val[0];
            REG_DECAY:      cfg_decay = val;
            REG_THRESHOLD:  cfg_thresh = val;
            REG_FULL_SCALE: cfg_full_scale = val;
            default:        ;
        endcase
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected reading level %0d volume %0d", $time,
                         out_data.meter_level, out_data.volume);
                errors++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (out_data.meter_level !== want.meter_level)
                begin
                    $display("%0t: meter_level expected %0d actual %0d", $time,
                             want.meter_level, out_data.meter_level);
                    errors++;
                end
                if (out_data.volume !== want.volume)
                begin
                    $display("%0t: volume expected %0d actual %0d", $time,
                             want.volume, out_data.volume);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    initial
    begin
        for (int c = 0; c < CYCLE_LIMIT; c++)
            @(posedge clk);
        $display("** rms_level_meter_with_decay_core: FAILED **");
        $finish;
    end

    initial
    begin
        int mode;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ROWS; i++)
        begin
            if (SCRIPT[i].is_reg)
            begin
                wait_idle();
                write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
                cfg_valid <= 1'b0;
            end
            else
                offer_item(SCRIPT[i].item, SCRIPT[i].typed, SCRIPT[i].reading);
        end

        for (int b = 0; b < BURSTS; b++)
        begin
            mode = b * 3 / BURSTS;
            wait_idle();
            send_idle = (mode == 0) ? 21 : (mode == 1) ? 65 : 0;
            recv_stall = (mode == 0) ? 65 : (mode == 1) ? 21 : 0;
            write_reg(REG_MUTED, CFG_W'(b % 5 == 3));
            case (b % 4)
                0:
                begin
                    write_reg(REG_DECAY, 16'h8000);
                    write_reg(REG_THRESHOLD, 16'd0);
                    write_reg(REG_FULL_SCALE, 16'd1);
                end
                1:
                begin
                    write_reg(REG_DECAY, 16'd0);
                    write_reg(REG_THRESHOLD, 16'h8000);
                    write_reg(REG_FULL_SCALE, 16'h8000);
                end
                2:
                begin
                    write_reg(REG_DECAY, CFG_W'($urandom_range(16384, 32768)));
                    write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 2000)));
                    write_reg(REG_FULL_SCALE, CFG_W'($urandom_range(1, 32768)));
                end
                default:
                begin
                    write_reg(REG_DECAY, DECAY_RST);
                    write_reg(REG_THRESHOLD, THRESHOLD_RST);
                    write_reg(REG_FULL_SCALE, CFG_W'($urandom_range(1000, 20000)));
                end
            endcase
            cfg_valid <= 1'b0;

            // unterminated run of mostly full-scale samples, closed by the frame length cap
            if (b == LONG_FRAME_BURST)
                for (int k = 0; k < LONG_FRAME_LEN; k++)
                    offer_item('{ACT_SAMPLE,
                                 ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h8000,
                                 1'b0}, 1'b0, '0);

            for (int k = 0; k < BURST_ITEMS; k++)
                offer_item(random_item(), 1'b0, '0);
        end

        wait_idle();
        if (errors == 0)
            $display("** rms_level_meter_with_decay_core: PASSED **");
        else
            $display("** rms_level_meter_with_decay_core: FAILED **");
        $finish;
    end

endmodule
